// ----- rtl/arap_pkg.sv -----
// Shared types and constants of the ASCII register access parser.
// Used by arap_ctrl, arap_dp and ascii_register_access_parser; no dependencies.
package arap_pkg;

   localparam int NUM_VARS    = 10;
   localparam int VALUE_CHARS = 6;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 4;
   localparam int VAL_W       = 16;
   localparam int STAT_W      = 2;
   localparam int CNT_W       = 3;
   localparam int BCD_DIGITS  = 5;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int PTR_W       = 3;
   localparam int STEP_W      = 4;

   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] CH_ZERO     = 8'd48;
   localparam logic [BYTE_W-1:0] CH_NINE     = 8'd57;
   localparam logic [BYTE_W-1:0] CH_ONE      = 8'd49;
   localparam logic [BYTE_W-1:0] CH_W_UP     = 8'd87;
   localparam logic [BYTE_W-1:0] CH_W_LO     = 8'd119;
   localparam logic [BYTE_W-1:0] CH_R_UP     = 8'd82;
   localparam logic [BYTE_W-1:0] CH_R_LO     = 8'd114;
   localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'd123;
   localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'd125;
   localparam logic [BYTE_W-1:0] CH_PLUS     = 8'd43;
   localparam logic [BYTE_W-1:0] CH_MINUS    = 8'd45;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'd9;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INDEX  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FORMAT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RW     = 2'd3;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_INDEX  = 3'd1,
      PH_DELIM1 = 3'd2,
      PH_RW     = 3'd3,
      PH_DELIM2 = 3'd4,
      PH_VALUE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      CV_BLANKS = 2'd0,
      CV_DIGITS = 2'd1,
      CV_DONE   = 2'd2
   } conv_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_ONE  = 2'd1,
      EV_READ = 2'd2
   } ev_type;

   typedef enum logic [1:0] {
      SEL_DIGIT = 2'd0,
      SEL_CR    = 2'd1,
      SEL_LF    = 2'd2,
      SEL_STAT  = 2'd3
   } sel_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PARSE = 8'b0000_0010,
      S_CONV  = 8'b0000_0100,
      S_LEAD  = 8'b0000_1000,
      S_DIGIT = 8'b0001_0000,
      S_CR    = 8'b0010_0000,
      S_LF    = 8'b0100_0000,
      S_STAT  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic    cap;
      logic    commit;
      logic    conv_step;
      logic    lead_load;
      logic    out_load;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      ev_type ev;
      logic   out_free;
      logic   conv_last;
      logic   digit_last;
   } sts_type;

endpackage

// ----- rtl/arap_ctrl.sv -----
// Controller of the ASCII register access parser: sequences capture, parse,
// binary-to-decimal conversion and reply output. Depends on arap_pkg.
module arap_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arap_pkg::sts_type sts,
   output arap_pkg::cmd_type cmd
);
   import arap_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.cap       = 1'b0;
      cmd.commit    = 1'b0;
      cmd.conv_step = 1'b0;
      cmd.lead_load = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.sel       = SEL_DIGIT;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = S_PARSE;
            end
         end
         S_PARSE: begin
            case (sts.ev)
               EV_ONE: begin
                  if (sts.out_free) begin
                     cmd.commit = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               EV_READ: begin
                  cmd.commit = 1'b1;
                  state_in   = S_CONV;
               end
               default: begin
                  cmd.commit = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = S_LEAD;
            end
         end
         S_LEAD: begin
            cmd.lead_load = 1'b1;
            state_in      = S_DIGIT;
         end
         S_DIGIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sel      = SEL_DIGIT;
               if (sts.digit_last) begin
                  state_in = S_CR;
               end
            end
         end
         S_CR: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sel      = SEL_CR;
               state_in     = S_LF;
            end
         end
         S_LF: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sel      = SEL_LF;
               state_in     = S_STAT;
            end
         end
         S_STAT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sel      = SEL_STAT;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/arap_dp.sv -----
// Datapath of the ASCII register access parser: frame parsing registers,
// value conversion, register file, decimal conversion and output register.
// Depends on arap_pkg.
module arap_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  arap_pkg::cmd_type             cmd,
   output arap_pkg::sts_type             sts,
   input  logic [arap_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                          csr_wr_en,
   input  logic [arap_pkg::BYTE_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [arap_pkg::BYTE_W-1:0]   rsp_text_byte,
   output logic [arap_pkg::STAT_W-1:0]   rsp_status_code,
   output logic [arap_pkg::IDX_W-1:0]    rsp_var_index,
   output logic [arap_pkg::VAL_W-1:0]    rsp_var_value,
   output logic                          rsp_last_result
);
   import arap_pkg::*;

   logic [BYTE_W-1:0] delim_ff;
   logic [BYTE_W-1:0] rx_ff;
   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  target_ff, target_in;
   logic [VAL_W-1:0]  accum_ff, accum_in;
   logic              neg_ff, neg_in;
   conv_type          cv_ff, cv_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VAL_W-1:0]  store_ff [NUM_VARS];

   logic [VAL_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BCD_W-1:0]  bcd_adj;
   logic [STEP_W-1:0] step_ff;
   logic [PTR_W-1:0]  ptr_ff, lead_ptr;
   logic [VAL_W-1:0]  rdval_ff;
   logic [3:0]        cur_digit;

   logic              out_valid_ff;
   logic              out_kind_ff;
   logic [BYTE_W-1:0] out_text_ff;
   logic [STAT_W-1:0] out_stat_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [VAL_W-1:0]  out_val_ff;
   logic              out_last_ff;

   ev_type            ev;
   logic              is_digit, is_blank, wr_en;
   logic [BYTE_W-1:0] idx_off;
   logic [VAL_W-1:0]  dval, acc_x10, f_accum, fin_accum, wval;
   logic              f_neg, fin_neg;
   conv_type          f_cv;
   logic [CNT_W-1:0]  cnt_inc;
   logic [STAT_W-1:0] st_code;
   logic [IDX_W-1:0]  st_idx;
   logic              st_val_en;

   assign is_digit = (rx_ff inside {[CH_ZERO:CH_NINE]});
   assign is_blank = (rx_ff == CH_SPACE) || (rx_ff inside {[CH_TAB:CH_CR]});
   assign dval     = {{(VAL_W-4){1'b0}}, rx_ff[3:0]};
   assign acc_x10  = (accum_ff << 3) + (accum_ff << 1);
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign idx_off  = rx_ff - CH_ZERO;

   always_comb begin
      f_accum = accum_ff;
      f_neg   = neg_ff;
      f_cv    = cv_ff;
      case (cv_ff)
         CV_BLANKS: begin
            if (is_blank) begin
               f_cv = CV_BLANKS;
            end else if (rx_ff == CH_PLUS) begin
               f_cv = CV_DIGITS;
            end else if (rx_ff == CH_MINUS) begin
               f_neg = 1'b1;
               f_cv  = CV_DIGITS;
            end else if (is_digit) begin
               f_accum = dval;
               f_cv    = CV_DIGITS;
            end else begin
               f_cv = CV_DONE;
            end
         end
         CV_DIGITS: begin
            if (is_digit) begin
               f_accum = acc_x10 + dval;
            end else begin
               f_cv = CV_DONE;
            end
         end
         default: begin
            f_cv = cv_ff;
         end
      endcase
   end

   always_comb begin
      ev        = EV_NONE;
      phase_in  = phase_ff;
      target_in = target_ff;
      accum_in  = accum_ff;
      neg_in    = neg_ff;
      cv_in     = cv_ff;
      cnt_in    = cnt_ff;
      st_code   = STAT_OK;
      st_idx    = target_ff;
      st_val_en = 1'b0;
      wr_en     = 1'b0;
      fin_accum = accum_ff;
      fin_neg   = neg_ff;
      case (phase_ff)
         PH_INDEX: begin
            if (idx_off >= BYTE_W'(NUM_VARS)) begin
               ev       = EV_ONE;
               st_code  = STAT_INDEX;
               st_idx   = '0;
               phase_in = PH_WAIT;
            end else begin
               target_in = idx_off[IDX_W-1:0];
               phase_in  = PH_DELIM1;
            end
         end
         PH_DELIM1: begin
            if (rx_ff != delim_ff) begin
               ev       = EV_ONE;
               st_code  = STAT_FORMAT;
               phase_in = PH_WAIT;
            end else begin
               phase_in = PH_RW;
            end
         end
         PH_RW: begin
            if (rx_ff inside {CH_W_UP, CH_W_LO, CH_ONE}) begin
               phase_in = PH_DELIM2;
            end else if (rx_ff inside {CH_R_UP, CH_R_LO, CH_ZERO}) begin
               ev       = EV_READ;
               phase_in = PH_WAIT;
            end else begin
               ev       = EV_ONE;
               st_code  = STAT_RW;
               phase_in = PH_WAIT;
            end
         end
         PH_DELIM2: begin
            if (rx_ff != delim_ff) begin
               ev       = EV_ONE;
               st_code  = STAT_FORMAT;
               phase_in = PH_WAIT;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (rx_ff == CH_RBRACE) begin
               ev        = EV_ONE;
               st_val_en = 1'b1;
               wr_en     = 1'b1;
               phase_in  = PH_WAIT;
            end else begin
               accum_in  = f_accum;
               neg_in    = f_neg;
               cv_in     = f_cv;
               cnt_in    = cnt_inc;
               fin_accum = f_accum;
               fin_neg   = f_neg;
               if (cnt_inc >= CNT_W'(VALUE_CHARS)) begin
                  ev        = EV_ONE;
                  st_val_en = 1'b1;
                  wr_en     = 1'b1;
                  phase_in  = PH_WAIT;
               end
            end
         end
         default: begin
            if (rx_ff == CH_LBRACE) begin
               accum_in = '0;
               neg_in   = 1'b0;
               cv_in    = CV_BLANKS;
               cnt_in   = '0;
               phase_in = PH_INDEX;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      endcase
   end

   assign wval = fin_neg ? VAL_W'(~fin_accum + VAL_W'(1)) : fin_accum;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else if (csr_wr_en) begin
         delim_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         rx_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         target_ff <= '0;
         accum_ff  <= '0;
         neg_ff    <= 1'b0;
         cv_ff     <= CV_BLANKS;
         cnt_ff    <= '0;
         for (int i = 0; i < NUM_VARS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         accum_ff  <= accum_in;
         neg_ff    <= neg_in;
         cv_ff     <= cv_in;
         cnt_ff    <= cnt_in;
         if (wr_en) begin
            store_ff[target_ff] <= wval;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
      bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VAL_W-1]};
      bin_in = {bin_ff[VAL_W-2:0], 1'b0};
   end

   always_comb begin
      lead_ptr = '0;
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_ptr = PTR_W'(i);
         end
      end
   end

   assign cur_digit = bcd_ff[4*ptr_ff +: 4];

   always_ff @(posedge clock) begin
      if (cmd.commit && (ev == EV_READ)) begin
         bin_ff   <= store_ff[target_ff];
         rdval_ff <= store_ff[target_ff];
         bcd_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.conv_step) begin
         bin_ff  <= bin_in;
         bcd_ff  <= bcd_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.lead_load) begin
         ptr_ff <= lead_ptr;
      end else if (cmd.out_load && (cmd.sel == SEL_DIGIT)) begin
         ptr_ff <= ptr_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load || (cmd.commit && (ev == EV_ONE))) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (ev == EV_ONE)) begin
         out_kind_ff <= 1'b0;
         out_text_ff <= '0;
         out_stat_ff <= st_code;
         out_idx_ff  <= st_idx;
         out_val_ff  <= st_val_en ? wval : '0;
         out_last_ff <= 1'b1;
      end else if (cmd.out_load) begin
         out_kind_ff <= 1'b1;
         out_stat_ff <= STAT_OK;
         out_idx_ff  <= '0;
         out_val_ff  <= '0;
         out_last_ff <= 1'b0;
         case (cmd.sel)
            SEL_DIGIT: out_text_ff <= CH_ZERO | {4'd0, cur_digit};
            SEL_CR:    out_text_ff <= CH_CR;
            SEL_LF:    out_text_ff <= CH_LF;
            SEL_STAT: begin
               out_kind_ff <= 1'b0;
               out_text_ff <= '0;
               out_idx_ff  <= target_ff;
               out_val_ff  <= rdval_ff;
               out_last_ff <= 1'b1;
            end
            default:   out_text_ff <= '0;
         endcase
      end
   end

   assign sts.ev         = ev;
   assign sts.out_free   = !out_valid_ff || rsp_ready;
   assign sts.conv_last  = (step_ff == STEP_W'(VAL_W - 1));
   assign sts.digit_last = (ptr_ff == '0);

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_text_byte   = out_text_ff;
   assign rsp_status_code = out_stat_ff;
   assign rsp_var_index   = out_idx_ff;
   assign rsp_var_value   = out_val_ff;
   assign rsp_last_result = out_last_ff;

endmodule

// ----- rtl/ascii_register_access_parser.sv -----
// A word is captured into a register and parsed in the following cycle; a status reply
// is then loaded into the output register, which waits while it still holds a word.
// A read runs the bit-serial binary-to-decimal loop, selects the leading digit and then
// sends each digit, CR, LF and the status word. A new word is taken only in idle, so a
// read command holds off input until its status word has been loaded.
// Reset (synchronous): parser waits for an open brace, delimiter is ',', registers zero.
module ascii_register_access_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [arap_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_result_kind,
   output logic [arap_pkg::BYTE_W-1:0] rsp_text_byte,
   output logic [arap_pkg::STAT_W-1:0] rsp_status_code,
   output logic [arap_pkg::IDX_W-1:0]  rsp_var_index,
   output logic [arap_pkg::VAL_W-1:0]  rsp_var_value,
   output logic                        rsp_last_result,
   input  logic                        csr_wr_en,
   input  logic [arap_pkg::BYTE_W-1:0] csr_wr_data
);
   import arap_pkg::*;

   cmd_type cmd;
   sts_type sts;

   arap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arap_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_rx_byte     (req_rx_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_status_code (rsp_status_code),
      .rsp_var_index   (rsp_var_index),
      .rsp_var_value   (rsp_var_value),
      .rsp_last_result (rsp_last_result)
   );

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on two consecutive cycles");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !rsp_result_kind)
      else $error("final word of a command is not a status word");

   a_error_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && (rsp_status_code != STAT_OK) |-> rsp_var_value == '0)
      else $error("error status carries a value");

   a_text_charset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |->
         ((rsp_text_byte >= CH_ZERO) && (rsp_text_byte <= CH_NINE)) ||
         (rsp_text_byte == CH_CR) || (rsp_text_byte == CH_LF))
      else $error("reply text is not a digit, CR or LF");

endmodule
